FILE: src/lbp_pkg.sv
`timescale 1ns / 1ps
package lbp_pkg;

  localparam int CODE_BITS = 8;
  localparam int NUM_BINS = 256;
  localparam int WIDTH_REG_BITS = 11;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 11'd1024;
  localparam int MIN_WIDTH = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_BITS = 3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef struct packed {
    logic                 vld;
    logic                 rd;
    logic                 clr;
    logic                 inc;
    logic [CODE_BITS-1:0] bin;
  } hist_req_t;

endpackage

FILE: src/lbp_line_store.sv
`timescale 1ns / 1ps
module lbp_line_store #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          op,
  input  logic                          fs,
  input  logic [PIXEL_BITS-1:0]         pixel,
  input  logic [lbp_pkg::CODE_BITS-1:0] bin,
  input  logic [lbp_pkg::WIDTH_REG_BITS-1:0] image_width,
  output lbp_pkg::hist_req_t            req
);
  import lbp_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > WIDTH_REG_BITS) ? COL_W + 1 : WIDTH_REG_BITS;
  localparam logic [1:0] ROW_FULL = 2'd2;

  logic [CMP_W-1:0] wreg;
  logic [CMP_W-1:0] act_width;
  logic [CMP_W-1:0] col_inc;
  logic [COL_W-1:0] col_r, col_nxt, col_eff;
  logic [1:0]       row_r, row_nxt, row_eff;
  logic             has_code;
  logic             rd_en;
  logic             wrap;

  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic [2*PIXEL_BITS-1:0] byp_data_r;
  logic                    byp_hit_r;
  logic [2*PIXEL_BITS-1:0] line_q;
  logic [2*PIXEL_BITS-1:0] wr_data;
  logic                    wr_en;

  logic                  s1_v_r;
  logic                  s1_op_r;
  logic                  s1_fs_r;
  logic                  s1_has_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [CODE_BITS-1:0]  s1_bin_r;

  logic [PIXEL_BITS-1:0] win_r [6];
  logic [PIXEL_BITS-1:0] up_cur, mid_cur, ctr;
  logic [CODE_BITS-1:0]  code;

  always_comb begin
    wreg = CMP_W'(image_width);
    if (wreg < CMP_W'(MIN_WIDTH)) begin
      act_width = CMP_W'(MIN_WIDTH);
    end else if (wreg > CMP_W'(MAX_WIDTH)) begin
      act_width = CMP_W'(MAX_WIDTH);
    end else begin
      act_width = wreg;
    end
  end

  always_comb begin
    col_eff  = fs ? '0 : col_r;
    row_eff  = fs ? '0 : row_r;
    has_code = (row_eff == ROW_FULL) && (col_eff >= COL_W'(2));
    col_inc  = CMP_W'(col_eff) + CMP_W'(1);
    wrap     = (col_inc >= act_width);
    col_nxt  = wrap ? '0 : col_inc[COL_W-1:0];
    row_nxt  = (wrap && (row_eff != ROW_FULL)) ? row_eff + 2'd1 : row_eff;
  end

  assign rd_en = acc && (op == OP_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (rd_en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign wr_en   = s1_v_r && (s1_op_r == OP_PUSH);
  assign line_q  = byp_hit_r ? byp_data_r : rd_q;
  assign up_cur  = line_q[PIXEL_BITS-1:0];
  assign mid_cur = line_q[2*PIXEL_BITS-1:PIXEL_BITS];
  assign wr_data = {s1_pix_r, mid_cur};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= line_mem[col_eff];
    end
    if (wr_en) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr_en && (s1_col_r == col_eff);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r  <= op;
      s1_fs_r  <= fs;
      s1_has_r <= has_code;
      s1_col_r <= col_eff;
      s1_pix_r <= pixel;
      s1_bin_r <= bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (wr_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= up_cur;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_cur;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_pix_r;
    end
  end

  assign ctr = win_r[3];

  always_comb begin
    code[7] = ctr < win_r[0];
    code[6] = ctr < win_r[1];
    code[5] = ctr < up_cur;
    code[4] = ctr < win_r[2];
    code[3] = ctr < mid_cur;
    code[2] = ctr < win_r[4];
    code[1] = ctr < win_r[5];
    code[0] = ctr < s1_pix_r;
  end

  always_comb begin
    req.vld = s1_v_r;
    req.rd  = (s1_op_r == OP_READ);
    req.clr = wr_en && s1_fs_r;
    req.inc = (s1_op_r == OP_PUSH) && s1_has_r;
    req.bin = (s1_op_r == OP_READ) ? s1_bin_r : code;
  end

endmodule

FILE: src/lbp_hist.sv
`timescale 1ns / 1ps
module lbp_hist #(
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbp_pkg::hist_req_t            req,
  output logic                          s2_busy,
  output logic                          push_vld,
  output logic                          push_kind,
  output logic [lbp_pkg::CODE_BITS-1:0] push_code,
  output logic [COUNT_BITS-1:0]         push_count
);
  import lbp_pkg::*;

  logic [COUNT_BITS-1:0] hist_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_q;
  logic [NUM_BINS-1:0]   valid_r, valid_nxt;

  logic                 s2_v_r;
  logic                 s2_rd_r;
  logic                 s2_clr_r;
  logic                 s2_inc_r;
  logic [CODE_BITS-1:0] s2_bin_r;

  logic                  fwd_v_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  wr_en;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;

  assign wr_en = s2_v_r && s2_inc_r;

  always_comb begin
    if (s2_clr_r) begin
      old_cnt = '0;
    end else if (fwd_v_r) begin
      old_cnt = fwd_data_r;
    end else if (valid_r[s2_bin_r]) begin
      old_cnt = rd_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (req.vld) begin
      rd_q <= hist_mem[req.bin];
    end
    if (wr_en) begin
      hist_mem[s2_bin_r] <= new_cnt;
    end
  end

  always_comb begin
    valid_nxt = (s2_v_r && s2_clr_r) ? '0 : valid_r;
    if (wr_en) begin
      valid_nxt[s2_bin_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      s2_v_r  <= req.vld;
      fwd_v_r <= wr_en && req.vld && (s2_bin_r == req.bin);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= new_cnt;
    if (req.vld) begin
      s2_rd_r  <= req.rd;
      s2_clr_r <= req.clr;
      s2_inc_r <= req.inc;
      s2_bin_r <= req.bin;
    end
  end

  assign s2_busy    = s2_v_r;
  assign push_vld   = s2_v_r && (s2_rd_r || s2_inc_r);
  assign push_kind  = s2_rd_r ? KIND_COUNT : KIND_CODE;
  assign push_code  = s2_rd_r ? '0 : s2_bin_r;
  assign push_count = s2_rd_r ? old_cnt : '0;

endmodule

FILE: src/lbp_out_fifo.sv
`timescale 1ns / 1ps
module lbp_out_fifo #(
  parameter int DATA_W = 33
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [DATA_W-1:0]                push_data,
  output logic                             pop_vld,
  input  logic                             pop_rdy,
  output logic [DATA_W-1:0]                pop_data,
  output logic [lbp_pkg::OUT_CNT_BITS-1:0] cnt
);
  import lbp_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  logic [DATA_W-1:0]       fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    pop;

  assign pop_vld  = (cnt_r != '0);
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = fifo_mem[rd_ptr_r];
  assign cnt      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OUT_CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OUT_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/lbp_histogram_top.sv
`timescale 1ns / 1ps
// Local binary pattern histogram over a raster-order grayscale stream.
// Input items carry either a pixel (op 0) or a histogram bin read (op 1).
// Each interior pixel centre yields one code item on the output once the
// pixel below and to the right of it arrives; border pixels yield nothing.
// Every code also counts into a 256-bin saturating histogram, and a read
// item returns one bin count. A pixel flagged as frame start clears the
// histogram and restarts the row and column positions.
// The image width register sits at byte address 0 of the configuration port.
// A result passes the line-store stage, the histogram stage and the output queue.
// Throughput: one item per cycle while in_tready is high. The line stores are
// one memory read at the accept edge and written back in the next cycle; the
// histogram is a read-modify-write memory with forwarding of the previous
// cycle's write, so equal codes on consecutive cycles do not stall.
// Results go through a four-entry output queue. in_tready drops when the
// queue plus the items still in flight would fill it, so a stalled receiver
// backs up the input without losing or repeating results.
// Reset clears the positions, window and histogram valid bits at once; no
// clearing pass is needed and input is accepted right after reset.
module lbp_histogram_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pixel, bin_index
  input  logic [((PIXEL_BITS+15)/8)*8-1:0] in_tdata,
  // op, frame_start
  input  logic [1:0]                    in_tuser,

  output logic                          out_tvalid,
  input  logic                          out_tready,
  // lbp_code, bin_count
  output logic [((COUNT_BITS+15)/8)*8-1:0] out_tdata,
  // kind
  output logic [0:0]                    out_tuser,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbp_pkg::*;

  localparam int IN_DATA_W  = ((PIXEL_BITS + 15) / 8) * 8;
  localparam int OUT_DATA_W = ((COUNT_BITS + 15) / 8) * 8;
  localparam int ENTRY_W    = 1 + CODE_BITS + COUNT_BITS;

  logic [WIDTH_REG_BITS-1:0] image_width_r;
  logic                      cfg_wr;

  logic                  acc;
  logic [PIXEL_BITS-1:0] in_pixel;
  logic [CODE_BITS-1:0]  in_bin;
  hist_req_t             req;

  logic                    s2_busy;
  logic                    push_vld;
  logic                    push_kind;
  logic [CODE_BITS-1:0]    push_code;
  logic [COUNT_BITS-1:0]   push_count;
  logic [ENTRY_W-1:0]      pop_data;
  logic [OUT_CNT_BITS-1:0] q_cnt;
  logic [OUT_CNT_BITS:0]   pending;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == REG_IMAGE_WIDTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_IMAGE_WIDTH) ? 32'(image_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
    end else if (cfg_wr) begin
      image_width_r <= cfg_pwdata[WIDTH_REG_BITS-1:0];
    end
  end

  assign pending = (OUT_CNT_BITS+1)'(q_cnt) + (OUT_CNT_BITS+1)'(req.vld)
                   + (OUT_CNT_BITS+1)'(s2_busy);
  assign in_tready = (pending < (OUT_CNT_BITS+1)'(OUT_DEPTH));
  assign acc       = in_tvalid && in_tready;
  assign in_pixel  = in_tdata[PIXEL_BITS-1:0];
  assign in_bin    = in_tdata[PIXEL_BITS+CODE_BITS-1:PIXEL_BITS];

  lbp_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_tuser[0]),
    .fs          (in_tuser[1]),
    .pixel       (in_pixel),
    .bin         (in_bin),
    .image_width (image_width_r),
    .req         (req)
  );

  lbp_hist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .s2_busy    (s2_busy),
    .push_vld   (push_vld),
    .push_kind  (push_kind),
    .push_code  (push_code),
    .push_count (push_count)
  );

  lbp_out_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_vld),
    .push_data ({push_count, push_code, push_kind}),
    .pop_vld   (out_tvalid),
    .pop_rdy   (out_tready),
    .pop_data  (pop_data),
    .cnt       (q_cnt)
  );

  assign out_tuser[0] = pop_data[0];
  assign out_tdata    = OUT_DATA_W'(pop_data[ENTRY_W-1:1]);

endmodule

FILE: src/lbp_chk.sv
`timescale 1ns / 1ps
module lbp_chk #(
  parameter int OUT_DATA_W = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser
);
  import lbp_pkg::*;

  // A code item never carries a count, and a count item never carries a code.
  a_code_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_CODE) |-> out_tdata[OUT_DATA_W-1:CODE_BITS] == '0)
    else $error("code item with nonzero count");

  a_count_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_COUNT) |-> out_tdata[CODE_BITS-1:0] == '0)
    else $error("count item with nonzero code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind lbp_histogram_top lbp_chk #(
  .OUT_DATA_W (((COUNT_BITS + 15) / 8) * 8)
) u_lbp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
